/* sv/colp_pkg.sv */
package colp_pkg;

  localparam int unsigned STAGE_COUNT = 256;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned STATE_W     = 32;
  localparam int unsigned FRAC_W      = 16;

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd53888;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COEF_W-1:0]          coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;

endpackage

/* sv/colp_if.sv */
interface colp_in_if;
  logic              valid;
  logic              ready;
  colp_pkg::sample_t sample_in;
  logic              restart;

  modport source (output valid, output sample_in, output restart, input ready);
  modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface colp_out_if;
  logic              valid;
  logic              ready;
  colp_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* sv/colp_ram.sv */
module colp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/colp_mac.sv */
// new = x + round((p * (old - x)) / 2^16), ties toward +inf
module colp_mac (
  input  colp_pkg::state_t x,
  input  colp_pkg::state_t old,
  input  colp_pkg::coef_t  p,
  output colp_pkg::state_t y
);

  localparam int unsigned DW = colp_pkg::STATE_W + 1;
  localparam int unsigned PW = DW + colp_pkg::COEF_W + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased;

  always_comb begin
    diff   = DW'(old) - DW'(x);
    prod   = $signed({1'b0, p}) * diff;
    biased = prod + (PW'(1) <<< (colp_pkg::FRAC_W - 1));
    y      = x + biased[colp_pkg::FRAC_W +: colp_pkg::STATE_W];
  end

endmodule

/* sv/cascaded_one_pole_lowpass.sv */
// Pass: each item runs through all N stages (N = STAGE_COUNT) in S_RUN, then S_FIN
// loads the result once the output is free; only then is a new item accepted. One
// shared MAC plus a RAM read and a write port update one stage state per cycle.
// Reset: coefficient returns to 53888, all stage states read as zero until the
// first item has been filtered; no clearing pass.
module cascaded_one_pole_lowpass #(
  parameter int unsigned STAGE_COUNT = colp_pkg::STAGE_COUNT,
  localparam int unsigned AW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  colp_pkg::coef_t  cfg_data,
  colp_in_if.sink          in_ch,
  colp_out_if.source       out_ch
);

  localparam logic [AW-1:0] LAST = AW'(STAGE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } fsm_t;

  fsm_t              state;
  logic [AW-1:0]     idx;
  colp_pkg::state_t  x;
  colp_pkg::coef_t   coef;
  logic              zero_old;
  logic              fresh;
  logic              out_valid;
  colp_pkg::sample_t out_sample;

  logic              accept;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  colp_pkg::state_t  rd_data;
  colp_pkg::state_t  old_eff;
  colp_pkg::state_t  x_next;
  logic              wr_en;
  logic              out_load;
  logic signed [colp_pkg::STATE_W:0] rnd;
  logic signed [colp_pkg::STATE_W-colp_pkg::FRAC_W:0] y_full;
  colp_pkg::sample_t y_sat;

  assign in_ch.ready       = (state == S_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;

  assign rd_en   = accept || (state == S_RUN && idx != LAST);
  assign rd_addr = (state == S_IDLE) ? '0 : AW'(idx + AW'(1));
  assign wr_en   = (state == S_RUN);
  assign old_eff = zero_old ? '0 : rd_data;

  colp_ram #(
    .WIDTH (colp_pkg::STATE_W),
    .DEPTH (STAGE_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (x_next),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  colp_mac u_mac (
    .x   (x),
    .old (old_eff),
    .p   (coef),
    .y   (x_next)
  );

  always_comb begin
    rnd    = (colp_pkg::STATE_W+1)'(x) + (colp_pkg::STATE_W+1)'(1 << (colp_pkg::FRAC_W - 1));
    y_full = rnd[colp_pkg::STATE_W:colp_pkg::FRAC_W];
    if (y_full > (colp_pkg::STATE_W-colp_pkg::FRAC_W+1)'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y_full < -(colp_pkg::STATE_W-colp_pkg::FRAC_W+1)'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_full[colp_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_load = (state == S_FIN) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      coef      <= colp_pkg::COEF_RESET;
      fresh     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        coef <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx == LAST) begin
            fresh <= 1'b0;
            state <= S_FIN;
          end else begin
            idx <= AW'(idx + AW'(1));
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x        <= colp_pkg::state_t'(in_ch.sample_in) <<< colp_pkg::FRAC_W;
      zero_old <= in_ch.restart || fresh;
    end else if (state == S_RUN) begin
      x <= x_next;
    end
    if (out_load) begin
      out_sample <= y_sat;
    end
  end

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN) && (idx == '0))
    else $error("pass did not start at stage zero");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (idx == LAST) |=> (state == S_FIN) && !fresh)
    else $error("pass did not finish after last stage");

  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !out_valid |=> out_valid)
    else $error("result not loaded into free output register");

  a_nowr: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !wr_en && (rd_en == accept))
    else $error("state changed outside a pass");
`endif

endmodule
